FILE: sv/lavm_pkg.sv
// Shared constants and arithmetic helpers for the look-at view matrix core.
package lavm_pkg;

   // Default number of fraction bits on all fixed-point ports
   localparam int FRAC_BITS_DEF = 16;
   // Width of one axis component on the result ports
   localparam int AXIS_BITS = 18;
   // Width of the position ports and the translations
   localparam int WORD_BITS = 32;
   // Square root stages: one result bit per stage for a 62-bit radicand
   localparam int SQRT_STEPS = 32;
   // Magnitudes are scaled so that the largest lies in [2^29, 2^30)
   localparam int NORM_TOP = 29;
   // Scratch width for rounding and saturation helpers
   localparam int WIDE_BITS = 80;

   localparam logic signed [WIDE_BITS-1:0] AXIS_MAX = 80'sd131071;
   localparam logic signed [WIDE_BITS-1:0] AXIS_MIN = -80'sd131072;
   localparam logic signed [WIDE_BITS-1:0] WORD_MAX = 80'sd2147483647;
   localparam logic signed [WIDE_BITS-1:0] WORD_MIN = -80'sd2147483648;

   // Register stages through one normalize unit
   function automatic int norm_latency(input int frac);
      return 6 + SQRT_STEPS + 1 + (frac + 1) + 1;
   endfunction

   // Divide by 2^frac, rounding half away from zero (one add, one shift)
   function automatic logic signed [WIDE_BITS-1:0] round_frac(
      input logic signed [WIDE_BITS-1:0] p,
      input int frac
   );
      logic signed [WIDE_BITS-1:0] half;
      half = 80'sd1 <<< (frac - 1);
      return (p + half - ((p < 0) ? 80'sd1 : 80'sd0)) >>> frac;
   endfunction

   // Clamp an axis component to [-1.0, 1.0], then to the port range
   function automatic logic [AXIS_BITS-1:0] axis_sat(
      input logic signed [WIDE_BITS-1:0] v,
      input int frac
   );
      logic signed [WIDE_BITS-1:0] one;
      logic signed [WIDE_BITS-1:0] t;
      one = 80'sd1 <<< frac;
      t = v;
      if (t > one) t = one;
      if (t < -one) t = -one;
      if (t > AXIS_MAX) t = AXIS_MAX;
      if (t < AXIS_MIN) t = AXIS_MIN;
      return t[AXIS_BITS-1:0];
   endfunction

   // Negate a rounded translation and clamp to the 32-bit range
   function automatic logic [WORD_BITS-1:0] shift_sat(input logic signed [WIDE_BITS-1:0] r);
      logic signed [WIDE_BITS-1:0] n;
      n = -r;
      if (n > WORD_MAX) n = WORD_MAX;
      if (n < WORD_MIN) n = WORD_MIN;
      return n[WORD_BITS-1:0];
   endfunction

endpackage

FILE: sv/lavm_norm3.sv
// Pipelined normalize unit for a signed 3-vector: scale, square root, divide.
module lavm_norm3 #(
   parameter int IW        = 33,
   parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic signed [IW-1:0]        in_vec  [3],
   output logic signed [FRAC_BITS+1:0] out_vec [3]
);

   localparam int SW = (IW > 30) ? IW : 30;
   localparam int PW = $clog2(SW) + 1;
   localparam int SQ = lavm_pkg::SQRT_STEPS;
   localparam int QN = FRAC_BITS + 1;
   localparam int NW = 31 + FRAC_BITS;
   localparam int OW = FRAC_BITS + 2;

   // front stages
   logic [IW-1:0]   mag1_ff [3];
   logic [2:0]      neg1_ff;
   logic [IW-1:0]   mag2_ff [3];
   logic [IW-1:0]   max2_ff;
   logic [2:0]      neg2_ff;
   logic [IW-1:0]   mag3_ff [3];
   logic [PW-1:0]   pos3_ff;
   logic            zero3_ff;
   logic [2:0]      neg3_ff;
   logic [29:0]     a4_ff   [3];
   logic [2:0]      neg4_ff;
   logic            zero4_ff;
   logic [59:0]     sq5_ff  [3];
   logic [29:0]     a5_ff   [3];
   logic [2:0]      neg5_ff;
   logic            zero5_ff;

   // square root stages
   logic [63:0]     rn_ff [SQ];
   logic [63:0]     rr_ff [SQ+1];
   logic [29:0]     sa_ff [SQ+1][3];
   logic [2:0]      sn_ff [SQ+1];
   logic            sz_ff [SQ+1];

   // divider stages
   logic [NW-1:0]   dr_ff [QN+1][3];
   logic [QN-1:0]   dq_ff [QN+1][3];
   logic [30:0]     dl_ff [QN];
   logic [2:0]      dn_ff [QN+1];
   logic            dz_ff [QN+1];

   logic signed [OW-1:0] out_ff [3];

   logic [IW-1:0]   max_in;
   logic [PW-1:0]   pos_in;
   logic [29:0]     a_in [3];

   // largest magnitude
   always_comb begin
      max_in = mag1_ff[0];
      if (mag1_ff[1] > max_in) max_in = mag1_ff[1];
      if (mag1_ff[2] > max_in) max_in = mag1_ff[2];
   end

   // position of the leading one of the largest magnitude
   always_comb begin
      pos_in = '0;
      for (int b = 0; b < IW; b++) begin
         if (max2_ff[b]) pos_in = PW'(b);
      end
   end

   // common shift that brings the leading one to bit 29
   always_comb begin
      logic [SW-1:0] ext;
      for (int i = 0; i < 3; i++) begin
         ext = SW'(mag3_ff[i]);
         if (pos3_ff >= PW'(lavm_pkg::NORM_TOP)) begin
            a_in[i] = 30'(ext >> (pos3_ff - PW'(lavm_pkg::NORM_TOP)));
         end else begin
            a_in[i] = 30'(ext << (PW'(lavm_pkg::NORM_TOP) - pos3_ff));
         end
      end
   end

   // magnitude, maximum, leading one, scaling, squares
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mag1_ff[i] <= in_vec[i][IW-1] ? IW'(-in_vec[i]) : IW'(in_vec[i]);
         neg1_ff[i] <= in_vec[i][IW-1];
         mag2_ff[i] <= mag1_ff[i];
         mag3_ff[i] <= mag2_ff[i];
         a4_ff[i]   <= a_in[i];
         sq5_ff[i]  <= 60'(a4_ff[i]) * 60'(a4_ff[i]);
         a5_ff[i]   <= a4_ff[i];
      end
      neg2_ff  <= neg1_ff;
      max2_ff  <= max_in;
      neg3_ff  <= neg2_ff;
      pos3_ff  <= pos_in;
      zero3_ff <= (max2_ff == '0);
      neg4_ff  <= neg3_ff;
      zero4_ff <= zero3_ff;
      neg5_ff  <= neg4_ff;
      zero5_ff <= zero4_ff;
   end

   // sum of squares, then one root bit per stage
   always_ff @(posedge clock) begin
      logic [63:0] trial;
      rn_ff[0] <= 64'(sq5_ff[0]) + 64'(sq5_ff[1]) + 64'(sq5_ff[2]);
      rr_ff[0] <= '0;
      sa_ff[0] <= a5_ff;
      sn_ff[0] <= neg5_ff;
      sz_ff[0] <= zero5_ff;
      for (int k = 1; k <= SQ; k++) begin
         trial = rr_ff[k-1] + (64'(1) << (62 - 2 * (k - 1)));
         if (rn_ff[k-1] >= trial) begin
            if (k < SQ) rn_ff[k] <= rn_ff[k-1] - trial;
            rr_ff[k] <= (rr_ff[k-1] >> 1) + (64'(1) << (62 - 2 * (k - 1)));
         end else begin
            if (k < SQ) rn_ff[k] <= rn_ff[k-1];
            rr_ff[k] <= rr_ff[k-1] >> 1;
         end
         sa_ff[k] <= sa_ff[k-1];
         sn_ff[k] <= sn_ff[k-1];
         sz_ff[k] <= sz_ff[k-1];
      end
   end

   // rounded numerator, then one quotient bit per stage, then sign
   always_ff @(posedge clock) begin
      logic [NW-1:0] cmp;
      for (int i = 0; i < 3; i++) begin
         dr_ff[0][i] <= (NW'(sa_ff[SQ][i]) << FRAC_BITS) + NW'(rr_ff[SQ][30:1]);
         dq_ff[0][i] <= '0;
      end
      dl_ff[0] <= rr_ff[SQ][30:0];
      dn_ff[0] <= sn_ff[SQ];
      dz_ff[0] <= sz_ff[SQ];
      for (int d = 1; d <= QN; d++) begin
         cmp = NW'(dl_ff[d-1]) << (QN - d);
         for (int i = 0; i < 3; i++) begin
            if (dr_ff[d-1][i] >= cmp) begin
               dr_ff[d][i] <= dr_ff[d-1][i] - cmp;
               dq_ff[d][i] <= {dq_ff[d-1][i][QN-2:0], 1'b1};
            end else begin
               dr_ff[d][i] <= dr_ff[d-1][i];
               dq_ff[d][i] <= {dq_ff[d-1][i][QN-2:0], 1'b0};
            end
         end
         if (d < QN) dl_ff[d] <= dl_ff[d-1];
         dn_ff[d] <= dn_ff[d-1];
         dz_ff[d] <= dz_ff[d-1];
      end
      for (int i = 0; i < 3; i++) begin
         if (dz_ff[QN]) begin
            out_ff[i] <= '0;
         end else if (dn_ff[QN][i]) begin
            out_ff[i] <= -$signed(OW'(dq_ff[QN][i]));
         end else begin
            out_ff[i] <= $signed(OW'(dq_ff[QN][i]));
         end
      end
   end

   assign out_vec = out_ff;

endmodule

FILE: sv/look_at_view_matrix_core.sv
// Look-at view matrix core: camera axes and translations, fully pipelined.
//
// Takes one camera (eye, target, up; signed fixed point with FRAC_BITS fraction
// bits) per cycle while start is high and busy is low; busy is high only during
// reset. Each transaction gives exactly one result, marked by rsp_strobe for one
// cycle. The path runs through two normalize units in series, each a 32-stage
// square root followed by a FRAC_BITS+1 stage restoring divider, plus the cross
// and dot product stages. There is no backpressure: the receiver must take every
// result in its strobe cycle. Eye equal to target gives an all-zero result; a
// zero up vector gives zero side and up axes and zero x and y translations.
module look_at_view_matrix_core #(
   parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_up_x,
   input  logic signed [31:0] req_up_y,
   input  logic signed [31:0] req_up_z,
   output logic               rsp_strobe,
   output logic signed [17:0] rsp_side_x,
   output logic signed [17:0] rsp_side_y,
   output logic signed [17:0] rsp_side_z,
   output logic signed [17:0] rsp_upaxis_x,
   output logic signed [17:0] rsp_upaxis_y,
   output logic signed [17:0] rsp_upaxis_z,
   output logic signed [17:0] rsp_back_x,
   output logic signed [17:0] rsp_back_y,
   output logic signed [17:0] rsp_back_z,
   output logic signed [31:0] rsp_shift_x,
   output logic signed [31:0] rsp_shift_y,
   output logic signed [31:0] rsp_shift_z
);

   localparam int F       = FRAC_BITS;
   localparam int AXW     = F + 2;
   localparam int CPW     = 2 * AXW;
   localparam int SRW     = CPW + 1;
   localparam int UPW     = SRW - F;
   localparam int DW      = UPW + 34;
   localparam int RW      = DW - F + 1;
   localparam int L       = lavm_pkg::norm_latency(F);
   localparam int T       = 2 * L + 2;
   localparam int OUT_STG = T + 7;
   localparam int AXIS_LIM = (F < 17) ? (1 << F) : 131071;

   logic                     accept;
   logic [OUT_STG:0]         vld_ff;

   logic signed [32:0]       diff_ff  [3];
   logic signed [31:0]       upv_ff   [3];
   logic signed [31:0]       eye_d_ff [T+4][3];

   logic signed [AXW-1:0]    back_v [3];
   logic signed [AXW-1:0]    upn_v  [3];
   logic signed [AXW-1:0]    side_v [3];

   logic signed [CPW-1:0]    cp_ff   [6];
   logic signed [SRW-1:0]    sraw_ff [3];
   logic signed [AXW-1:0]    back_d_ff [L+2][3];

   logic signed [CPW-1:0]    bs_ff [6];
   logic signed [DW-1:0]     se_ff [3];
   logic signed [DW-1:0]     be_ff [3];
   logic signed [AXW-1:0]    side_c_ff [6][3];
   logic signed [AXW-1:0]    back_c_ff [6][3];
   logic signed [SRW-1:0]    uraw_ff [3];
   logic signed [DW-1:0]     dots_ff;
   logic signed [DW-1:0]     dotb_ff;
   logic signed [UPW-1:0]    upax_ff [3];
   logic signed [RW-1:0]     rs_ff;
   logic signed [RW-1:0]     rb_ff;
   logic signed [DW-1:0]     ue_ff [3];
   logic signed [UPW-1:0]    upax_c_ff [3][3];
   logic [31:0]              shx_c_ff [3];
   logic [31:0]              shz_c_ff [3];
   logic signed [DW-1:0]     dotu_ff;
   logic signed [RW-1:0]     ru_ff;

   logic [17:0]              side_o_ff [3];
   logic [17:0]              upax_o_ff [3];
   logic [17:0]              back_o_ff [3];
   logic [31:0]              shx_o_ff;
   logic [31:0]              shy_o_ff;
   logic [31:0]              shz_o_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[OUT_STG-1:0], accept};
      end
   end

   // input registers and eye delay line
   always_ff @(posedge clock) begin
      diff_ff[0] <= 33'(req_eye_x) - 33'(req_target_x);
      diff_ff[1] <= 33'(req_eye_y) - 33'(req_target_y);
      diff_ff[2] <= 33'(req_eye_z) - 33'(req_target_z);
      upv_ff[0]  <= req_up_x;
      upv_ff[1]  <= req_up_y;
      upv_ff[2]  <= req_up_z;
      eye_d_ff[0][0] <= req_eye_x;
      eye_d_ff[0][1] <= req_eye_y;
      eye_d_ff[0][2] <= req_eye_z;
      for (int k = 1; k < T + 4; k++) begin
         eye_d_ff[k] <= eye_d_ff[k-1];
      end
   end

   // backward axis and normalized up
   lavm_norm3 #(.IW(33), .FRAC_BITS(F)) u_norm_back (
      .clock   (clock),
      .in_vec  (diff_ff),
      .out_vec (back_v)
   );

   lavm_norm3 #(.IW(32), .FRAC_BITS(F)) u_norm_up (
      .clock   (clock),
      .in_vec  (upv_ff),
      .out_vec (upn_v)
   );

   // side axis before normalizing: up x back
   always_ff @(posedge clock) begin
      cp_ff[0] <= upn_v[1] * back_v[2];
      cp_ff[1] <= upn_v[2] * back_v[1];
      cp_ff[2] <= upn_v[2] * back_v[0];
      cp_ff[3] <= upn_v[0] * back_v[2];
      cp_ff[4] <= upn_v[0] * back_v[1];
      cp_ff[5] <= upn_v[1] * back_v[0];
      sraw_ff[0] <= SRW'(cp_ff[0]) - SRW'(cp_ff[1]);
      sraw_ff[1] <= SRW'(cp_ff[2]) - SRW'(cp_ff[3]);
      sraw_ff[2] <= SRW'(cp_ff[4]) - SRW'(cp_ff[5]);
      back_d_ff[0] <= back_v;
      for (int k = 1; k < L + 2; k++) begin
         back_d_ff[k] <= back_d_ff[k-1];
      end
   end

   lavm_norm3 #(.IW(SRW), .FRAC_BITS(F)) u_norm_side (
      .clock   (clock),
      .in_vec  (sraw_ff),
      .out_vec (side_v)
   );

   // true up axis and translations
   always_ff @(posedge clock) begin
      // products of back, side and eye
      bs_ff[0] <= back_d_ff[L+1][1] * side_v[2];
      bs_ff[1] <= back_d_ff[L+1][2] * side_v[1];
      bs_ff[2] <= back_d_ff[L+1][2] * side_v[0];
      bs_ff[3] <= back_d_ff[L+1][0] * side_v[2];
      bs_ff[4] <= back_d_ff[L+1][0] * side_v[1];
      bs_ff[5] <= back_d_ff[L+1][1] * side_v[0];
      for (int i = 0; i < 3; i++) begin
         se_ff[i] <= side_v[i] * eye_d_ff[T][i];
         be_ff[i] <= back_d_ff[L+1][i] * eye_d_ff[T][i];
      end
      side_c_ff[0] <= side_v;
      back_c_ff[0] <= back_d_ff[L+1];
      for (int k = 1; k < 6; k++) begin
         side_c_ff[k] <= side_c_ff[k-1];
         back_c_ff[k] <= back_c_ff[k-1];
      end

      // cross differences and dot sums
      uraw_ff[0] <= SRW'(bs_ff[0]) - SRW'(bs_ff[1]);
      uraw_ff[1] <= SRW'(bs_ff[2]) - SRW'(bs_ff[3]);
      uraw_ff[2] <= SRW'(bs_ff[4]) - SRW'(bs_ff[5]);
      dots_ff <= se_ff[0] + se_ff[1] + se_ff[2];
      dotb_ff <= be_ff[0] + be_ff[1] + be_ff[2];

      // rounding
      for (int i = 0; i < 3; i++) begin
         upax_ff[i] <= UPW'(lavm_pkg::round_frac(80'(uraw_ff[i]), F));
      end
      rs_ff <= RW'(lavm_pkg::round_frac(80'(dots_ff), F));
      rb_ff <= RW'(lavm_pkg::round_frac(80'(dotb_ff), F));

      // up axis dot eye; side and back translations saturate
      for (int i = 0; i < 3; i++) begin
         ue_ff[i] <= upax_ff[i] * eye_d_ff[T+3][i];
      end
      upax_c_ff[0] <= upax_ff;
      upax_c_ff[1] <= upax_c_ff[0];
      upax_c_ff[2] <= upax_c_ff[1];
      shx_c_ff[0] <= lavm_pkg::shift_sat(80'(rs_ff));
      shz_c_ff[0] <= lavm_pkg::shift_sat(80'(rb_ff));
      shx_c_ff[1] <= shx_c_ff[0];
      shz_c_ff[1] <= shz_c_ff[0];
      shx_c_ff[2] <= shx_c_ff[1];
      shz_c_ff[2] <= shz_c_ff[1];

      dotu_ff <= ue_ff[0] + ue_ff[1] + ue_ff[2];
      ru_ff   <= RW'(lavm_pkg::round_frac(80'(dotu_ff), F));

      // output registers
      for (int i = 0; i < 3; i++) begin
         side_o_ff[i] <= lavm_pkg::axis_sat(80'(side_c_ff[5][i]), F);
         back_o_ff[i] <= lavm_pkg::axis_sat(80'(back_c_ff[5][i]), F);
         upax_o_ff[i] <= lavm_pkg::axis_sat(80'(upax_c_ff[2][i]), F);
      end
      shx_o_ff <= shx_c_ff[2];
      shy_o_ff <= lavm_pkg::shift_sat(80'(ru_ff));
      shz_o_ff <= shz_c_ff[2];
   end

   assign rsp_strobe   = vld_ff[OUT_STG];
   assign rsp_side_x   = $signed(side_o_ff[0]);
   assign rsp_side_y   = $signed(side_o_ff[1]);
   assign rsp_side_z   = $signed(side_o_ff[2]);
   assign rsp_upaxis_x = $signed(upax_o_ff[0]);
   assign rsp_upaxis_y = $signed(upax_o_ff[1]);
   assign rsp_upaxis_z = $signed(upax_o_ff[2]);
   assign rsp_back_x   = $signed(back_o_ff[0]);
   assign rsp_back_y   = $signed(back_o_ff[1]);
   assign rsp_back_z   = $signed(back_o_ff[2]);
   assign rsp_shift_x  = $signed(shx_o_ff);
   assign rsp_shift_y  = $signed(shy_o_ff);
   assign rsp_shift_z  = $signed(shz_o_ff);

   // every accepted transaction comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(OUT_STG + 1) rsp_strobe)
      else $error("accepted transaction produced no result");

   // no result without a transaction accepted at the matching edge
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, OUT_STG + 1))
      else $error("result without matching transaction");

   // eye equal to target yields an all-zero result
   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      (accept && req_eye_x == req_target_x && req_eye_y == req_target_y &&
       req_eye_z == req_target_z) |-> ##(OUT_STG + 1)
      (rsp_back_x == 0 && rsp_back_y == 0 && rsp_back_z == 0 &&
       rsp_side_x == 0 && rsp_side_y == 0 && rsp_side_z == 0 &&
       rsp_upaxis_x == 0 && rsp_upaxis_y == 0 && rsp_upaxis_z == 0 &&
       rsp_shift_x == 0 && rsp_shift_y == 0 && rsp_shift_z == 0))
      else $error("degenerate camera gave a nonzero result");

   // back x, side y and up axis z components stay within unit range
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($signed(rsp_back_x) <= AXIS_LIM && $signed(rsp_back_x) >= -AXIS_LIM &&
                      $signed(rsp_side_y) <= AXIS_LIM && $signed(rsp_side_y) >= -AXIS_LIM &&
                      $signed(rsp_upaxis_z) <= AXIS_LIM &&
                      $signed(rsp_upaxis_z) >= -AXIS_LIM))
      else $error("axis component outside unit range");

endmodule

FILE: tb/tb_look_at_view_matrix_core.sv
// Self-checking testbench for the look-at view matrix core.
module tb_look_at_view_matrix_core;

   localparam int FRAC = lavm_pkg::FRAC_BITS_DEF;
   localparam int LATENCY = 2 * (FRAC + 41) + 10;
   localparam int WATCHDOG_LIMIT = 4 * LATENCY + 200;
   localparam int RANDOM_ITEMS = 800;

   typedef struct {
      logic signed [31:0] eye [3];
      logic signed [31:0] target [3];
      logic signed [31:0] up [3];
   } camera_type;

   typedef struct {
      logic [17:0] axis [9];
      logic [31:0] shift [3];
   } view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
   logic signed [31:0] tgt_x = '0, tgt_y = '0, tgt_z = '0;
   logic signed [31:0] up_x = '0, up_y = '0, up_z = '0;
   logic rsp_strobe;
   logic signed [17:0] side_x, side_y, side_z, upa_x, upa_y, upa_z, back_x, back_y, back_z;
   logic signed [31:0] shift_x, shift_y, shift_z;

   camera_type pending_cameras [$];
   view_type expected_views [$];
   int gap_plan [$];
   int drain_marks [$];
   int mismatches = 0;
   int views_checked = 0;
   int cameras_sent = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   bit stimulus_done = 0;
   bit drain_wait = 0;

   always #6 clock = ~clock;

   look_at_view_matrix_core #(.FRAC_BITS(FRAC)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_eye_x(eye_x), .req_eye_y(eye_y), .req_eye_z(eye_z),
      .req_target_x(tgt_x), .req_target_y(tgt_y), .req_target_z(tgt_z),
      .req_up_x(up_x), .req_up_y(up_y), .req_up_z(up_z),
      .rsp_strobe(rsp_strobe),
      .rsp_side_x(side_x), .rsp_side_y(side_y), .rsp_side_z(side_z),
      .rsp_upaxis_x(upa_x), .rsp_upaxis_y(upa_y), .rsp_upaxis_z(upa_z),
      .rsp_back_x(back_x), .rsp_back_y(back_y), .rsp_back_z(back_z),
      .rsp_shift_x(shift_x), .rsp_shift_y(shift_y), .rsp_shift_z(shift_z)
   );

   // ---------------- golden arithmetic ----------------
   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Scale to [2^29, 2^30), divide each magnitude by the rounded-down length
   task automatic unit_vector(input logic signed [63:0] v [3],
                              output logic signed [63:0] u [3]);
      logic [63:0] a [3];
      logic [63:0] top, len, q;
      for (int i = 0; i < 3; i++) a[i] = magnitude(v[i]);
      top = a[0];
      if (a[1] > top) top = a[1];
      if (a[2] > top) top = a[2];
      if (top == 0) begin
         for (int i = 0; i < 3; i++) u[i] = 0;
         return;
      end
      while (top >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
         top = top >> 1;
      end
      while (top < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
         top = top << 1;
      end
      len = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      for (int i = 0; i < 3; i++) begin
         q = ((a[i] << FRAC) + (len >> 1)) / len;
         u[i] = (v[i] < 0) ? -$signed(q) : $signed(q);
      end
   endtask

   task automatic cross_product(input logic signed [63:0] a [3],
                                input logic signed [63:0] b [3],
                                output logic signed [63:0] c [3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
   endtask

   function automatic logic signed [63:0] drop_frac(input logic signed [63:0] p);
      logic [63:0] r;
      r = (magnitude(p) + (64'd1 << (FRAC - 1))) >> FRAC;
      return (p < 0) ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic [17:0] clamp_axis(input logic signed [63:0] v);
      logic signed [63:0] one;
      one = 64'sd1 <<< FRAC;
      if (v > one) v = one;
      if (v < -one) v = -one;
      if (v > 64'sd131071) v = 64'sd131071;
      if (v < -64'sd131072) v = -64'sd131072;
      return v[17:0];
   endfunction

   function automatic logic [31:0] translation(input logic signed [63:0] ax [3],
                                               input logic signed [63:0] e [3]);
      logic signed [63:0] r;
      r = -drop_frac(ax[0] * e[0] + ax[1] * e[1] + ax[2] * e[2]);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   task automatic predict_view(input camera_type c, output view_type v);
      logic signed [63:0] e [3], d [3], u [3], un [3], bk [3], sr [3], sd [3];
      logic signed [63:0] ur [3], ua [3];
      for (int i = 0; i < 3; i++) begin
         e[i] = c.eye[i];
         d[i] = 64'(c.eye[i]) - 64'(c.target[i]);
         u[i] = c.up[i];
      end
      unit_vector(d, bk);
      unit_vector(u, un);
      cross_product(un, bk, sr);
      unit_vector(sr, sd);
      cross_product(bk, sd, ur);
      for (int i = 0; i < 3; i++) ua[i] = drop_frac(ur[i]);
      for (int i = 0; i < 3; i++) begin
         v.axis[i] = clamp_axis(sd[i]);
         v.axis[3 + i] = clamp_axis(ua[i]);
         v.axis[6 + i] = clamp_axis(bk[i]);
      end
      v.shift[0] = translation(sd, e);
      v.shift[1] = translation(ua, e);
      v.shift[2] = translation(bk, e);
   endtask

   // ---------------- stimulus helpers ----------------
   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
         2: return $signed($urandom) >>> $urandom_range(0, 31);
         3: return ($urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000);
         default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      endcase
   endfunction

   task automatic queue_camera(input logic signed [31:0] ex, ey, ez, tx, ty, tz,
                               ux, uy, uz);
      camera_type c;
      c.eye = '{ex, ey, ez};
      c.target = '{tx, ty, tz};
      c.up = '{ux, uy, uz};
      pending_cameras.push_back(c);
      gap_plan.push_back(($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0);
   endtask

   initial begin
      int kind;
      logic signed [31:0] w [9];
      logic signed [31:0] sc;
      logic signed [31:0] dv;
      localparam logic signed [31:0] ONE = 32'sh0001_0000;
      localparam logic signed [31:0] MAXW = 32'sh7fff_ffff;
      localparam logic signed [31:0] MINW = 32'sh8000_0000;
      // Directed: typical camera, extremes, eye on target, degenerate up
      queue_camera(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
      queue_camera(3 * ONE, 2 * ONE, ONE, 0, 0, 0, 0, ONE, 0);
      queue_camera(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0);
      queue_camera(MAXW, MINW, MAXW, MAXW, MINW, MAXW, ONE, 0, 0);
      queue_camera(0, 0, ONE, 0, 0, 0, 0, 0, 0);
      queue_camera(0, 0, ONE, 0, 0, 0, 0, 0, 7 * ONE);
      queue_camera(0, 0, ONE, 0, 0, 0, 0, 0, -3);
      queue_camera(MAXW, MAXW, MAXW, MINW, MINW, MINW, MAXW, MINW, MAXW);
      queue_camera(MINW, MINW, MINW, MAXW, MAXW, MAXW, MINW, MAXW, MINW);
      queue_camera(MAXW, MINW, 0, MINW, MAXW, 0, 0, 0, MINW);
      queue_camera(1, 0, 0, 0, 0, 0, 0, 1, 0);
      queue_camera(-1, -1, -1, 0, 0, 0, MINW, MINW, MINW);
      queue_camera(-1, -1, -1, -1, -1, -1, MAXW, MAXW, MAXW);
      queue_camera(MAXW, MAXW, MAXW, 0, 0, 0, 0, ONE, 0);
      queue_camera(MINW, MINW, MINW, 0, 0, 0, 0, 0, ONE);
      queue_camera(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                   32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1, -1, 1);
      drain_marks.push_back(pending_cameras.size());
      // Random cameras, some with eye on target, up along the view or zero up
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         for (int i = 0; i < 9; i++) w[i] = rand_word();
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            w[3] = w[0]; w[4] = w[1]; w[5] = w[2];
         end else if (kind == 1) begin
            // small view direction, up an exact multiple of it
            sc = $signed($urandom_range(1, 64)) * (($urandom_range(0, 1) != 0) ? 1 : -1);
            for (int i = 0; i < 3; i++) begin
               dv = w[i] >>> 7;
               w[3 + i] = w[i] - dv;
               w[6 + i] = dv * sc;
            end
         end else if (kind == 2) begin
            w[6] = 0; w[7] = 0; w[8] = 0;
         end
         queue_camera(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]);
         if (n == RANDOM_ITEMS / 2) drain_marks.push_back(pending_cameras.size());
      end
   end

   // ---------------- driver ----------------
   always @(posedge clock) begin
      camera_type c;
      view_type v;
      if (start && !busy && !reset) begin
         predict_view(pending_cameras.pop_front(), v);
         expected_views.push_back(v);
         cameras_sent <= cameras_sent + 1;
         void'(gap_plan.pop_front());
      end
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         if (pending_cameras.size() == 0) begin
            start <= 1'b0;
            stimulus_done <= 1'b1;
         end else if (gap_plan[0] == 0 && !(drain_marks.size() != 0 &&
                      drain_marks[0] == pending_cameras.size())) begin
            // next transaction follows back to back
            c = pending_cameras[0];
            eye_x <= c.eye[0]; eye_y <= c.eye[1]; eye_z <= c.eye[2];
            tgt_x <= c.target[0]; tgt_y <= c.target[1]; tgt_z <= c.target[2];
            up_x <= c.up[0]; up_y <= c.up[1]; up_z <= c.up[2];
            start <= 1'b1;
         end else begin
            start <= 1'b0;
            gap_left <= (gap_plan[0] > 0) ? gap_plan[0] - 1 : 0;
         end
      end else if (start) begin
         start <= 1'b1;
      end else if (drain_marks.size() != 0 && drain_marks[0] ==
                   pending_cameras.size() + 0 && !drain_wait &&
                   expected_views.size() != 0) begin
         drain_wait <= 1'b1;
      end else if (drain_wait) begin
         if (expected_views.size() == 0) begin
            drain_wait <= 1'b0;
            void'(drain_marks.pop_front());
         end
      end else if (gap_left != 0) begin
         gap_left <= gap_left - 1;
      end else if (pending_cameras.size() != 0) begin
         c = pending_cameras[0];
         eye_x <= c.eye[0]; eye_y <= c.eye[1]; eye_z <= c.eye[2];
         tgt_x <= c.target[0]; tgt_y <= c.target[1]; tgt_z <= c.target[2];
         up_x <= c.up[0]; up_y <= c.up[1]; up_z <= c.up[2];
         start <= 1'b1;
      end
   end

   // ---------------- monitor ----------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR view %0d: %s got %h expected %h", views_checked, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      view_type want;
      logic [17:0] got_axis [9];
      logic [31:0] got_shift [3];
      string names [12];
      names = '{"side_x", "side_y", "side_z", "upaxis_x", "upaxis_y", "upaxis_z",
                "back_x", "back_y", "back_z", "shift_x", "shift_y", "shift_z"};
      if (!reset && rsp_strobe) begin
         if (expected_views.size() == 0) begin
            $display("ERROR: result with no transaction outstanding");
            mismatches++;
         end else begin
            want = expected_views.pop_front();
            got_axis = '{side_x, side_y, side_z, upa_x, upa_y, upa_z,
                         back_x, back_y, back_z};
            got_shift = '{shift_x, shift_y, shift_z};
            for (int i = 0; i < 9; i++)
               if (got_axis[i] !== want.axis[i])
                  report_mismatch(names[i], 32'(got_axis[i]), 32'(want.axis[i]));
            for (int i = 0; i < 3; i++)
               if (got_shift[i] !== want.shift[i])
                  report_mismatch(names[9 + i], got_shift[i], want.shift[i]);
         end
         views_checked++;
      end
   end

   // ---------------- watchdog and end of run ----------------
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no progress for %0d cycles", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && expected_views.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      $display("Sent %0d camera transactions, checked %0d view results, %0d mismatches",
               cameras_sent, views_checked, mismatches);
      if (mismatches == 0 && expected_views.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
